### rtl/aabb_mtv_collision_resolve_unit_assert.svh
// Assertion macros for the collision resolve unit.
`ifndef AABB_MTV_COLLISION_RESOLVE_UNIT_ASSERT_SVH
`define AABB_MTV_COLLISION_RESOLVE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ACR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define ACR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/acr_pkg.sv
package acr_pkg;

  localparam int unsigned CoordBits = 16;

  typedef logic [CoordBits-1:0] coord_t;

  localparam logic [3:0] SideLeft   = 4'b0001;
  localparam logic [3:0] SideRight  = 4'b0010;
  localparam logic [3:0] SideTop    = 4'b0100;
  localparam logic [3:0] SideBottom = 4'b1000;
  localparam logic [3:0] SideNone   = 4'b0000;

  localparam logic [7:0] HitMax = 8'hFF;

  typedef struct packed {
    logic               first_of_run;
    logic               last_of_run;
    logic               has_static;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [7:0]         moving_w;
    logic [7:0]         moving_h;
    logic signed [15:0] static_x;
    logic signed [15:0] static_y;
    logic [7:0]         static_w;
    logic [7:0]         static_h;
  } req_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [3:0]         sides_seen;
    logic [7:0]         hit_count;
    logic               this_hit;
    logic               run_done;
  } res_t;

  function automatic coord_t from16(logic signed [15:0] v);
    logic signed [31:0] ext;
    ext = 32'(v);
    return ext[CoordBits-1:0];
  endfunction

  function automatic logic signed [15:0] to16(coord_t v);
    logic signed [31:0] ext;
    ext = 32'(signed'(v));
    return ext[15:0];
  endfunction

  function automatic logic positive(coord_t v);
    return (v != '0) && !v[CoordBits-1];
  endfunction

endpackage

### rtl/acr_if.sv
interface acr_req_if;
  logic          valid;
  logic          ready;
  acr_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acr_res_if;
  logic          valid;
  logic          ready;
  acr_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/aabb_mtv_collision_resolve_unit.sv
// Collision resolve unit: pushes a moving box out of a run of static boxes.
// req_i carries one request per static box (valid/ready). The first request
// of a run loads the moving box start and size and clears sides and hits;
// has_static low gives a request with no box to test. res_o returns one
// result per request, in order: position after the push, accumulated sides,
// saturating hit count, this request's hit flag and the end-of-run mark.
// A taken request is registered in the input register, resolved against
// the carried state and registered again in the result register on res_o.
// Throughput: one request per cycle while res_o does not stall; the input
// and result registers each hold one request, so one more request is
// taken while a result waits. The carried-position loop sets that rate.
// When res_o stalls, the result holds and the input register fills, then
// req_i.ready drops until the receiver takes the result.
// Reset clears position, size, sides, hits and both valid flags.
`include "aabb_mtv_collision_resolve_unit_assert.svh"

module aabb_mtv_collision_resolve_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  acr_req_if.sink   req_i,
  acr_res_if.source res_o
);

  logic           in_valid_q;
  acr_pkg::req_t  in_q;
  logic           out_valid_q;
  acr_pkg::res_t  out_q;

  acr_pkg::coord_t cur_x_q, cur_x_d;
  acr_pkg::coord_t cur_y_q, cur_y_d;
  logic [7:0]      box_w_q, box_w_d;
  logic [7:0]      box_h_q, box_h_d;
  logic [3:0]      sides_q, sides_d;
  logic [7:0]      hits_q, hits_d;

  logic out_free;
  logic advance;

  acr_pkg::coord_t base_x, base_y, sx, sy;
  acr_pkg::coord_t pl, pr, pt, pb, mx, my;
  logic [3:0]      base_sides;
  logic [7:0]      base_hits;
  logic            hit, l_lt, t_lt;

  assign out_free    = !out_valid_q || res_o.ready;
  assign advance     = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || out_free;

  always_comb begin
    if (in_q.first_of_run) begin
      base_x     = acr_pkg::from16(in_q.start_x);
      base_y     = acr_pkg::from16(in_q.start_y);
      box_w_d    = in_q.moving_w;
      box_h_d    = in_q.moving_h;
      base_sides = acr_pkg::SideNone;
      base_hits  = '0;
    end else begin
      base_x     = cur_x_q;
      base_y     = cur_y_q;
      box_w_d    = box_w_q;
      box_h_d    = box_h_q;
      base_sides = sides_q;
      base_hits  = hits_q;
    end

    sx = acr_pkg::from16(in_q.static_x);
    sy = acr_pkg::from16(in_q.static_y);
    pl = sx + acr_pkg::coord_t'(in_q.static_w) - base_x;
    pr = base_x + acr_pkg::coord_t'(box_w_d) - sx;
    pt = sy + acr_pkg::coord_t'(in_q.static_h) - base_y;
    pb = base_y + acr_pkg::coord_t'(box_h_d) - sy;

    hit  = in_q.has_static && acr_pkg::positive(pl) && acr_pkg::positive(pr)
           && acr_pkg::positive(pt) && acr_pkg::positive(pb);
    l_lt = pl < pr;
    t_lt = pt < pb;
    mx   = l_lt ? pl : pr;
    my   = t_lt ? pt : pb;

    cur_x_d = base_x;
    cur_y_d = base_y;
    sides_d = base_sides;
    hits_d  = base_hits;
    if (hit) begin
      if (mx <= my) begin
        cur_x_d = l_lt ? base_x + pl : base_x - pr;
      end else begin
        cur_y_d = t_lt ? base_y + pt : base_y - pb;
      end
      sides_d = base_sides | (l_lt ? acr_pkg::SideLeft : acr_pkg::SideRight)
                           | (t_lt ? acr_pkg::SideTop : acr_pkg::SideBottom);
      if (base_hits != acr_pkg::HitMax) begin
        hits_d = base_hits + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      box_w_q     <= '0;
      box_h_q     <= '0;
      sides_q     <= '0;
      hits_q      <= '0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        cur_x_q     <= cur_x_d;
        cur_y_q     <= cur_y_d;
        box_w_q     <= box_w_d;
        box_h_q     <= box_h_d;
        sides_q     <= sides_d;
        hits_q      <= hits_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= req_i.data;
    end
    if (advance) begin
      out_q.pos_x      <= acr_pkg::to16(cur_x_d);
      out_q.pos_y      <= acr_pkg::to16(cur_y_d);
      out_q.sides_seen <= sides_d;
      out_q.hit_count  <= hits_d;
      out_q.this_hit   <= hit;
      out_q.run_done   <= in_q.last_of_run;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  `ACR_ASSERT_NEXT(a_adv_gives_result, advance, out_valid_q, "request lost before result")
  `ACR_ASSERT_NEXT(a_hits_monotonic, advance && !in_q.first_of_run,
                   hits_q >= $past(hits_q), "hit count fell within a run")
  `ACR_ASSERT_NOW(a_hit_counted, out_valid_q && out_q.this_hit,
                  out_q.hit_count != 8'd0, "hit flagged with zero hit count")
  `ACR_ASSERT_NOW(a_sides_match_hits, out_valid_q,
                  (out_q.hit_count == 8'd0) == (out_q.sides_seen == acr_pkg::SideNone),
                  "sides and hit count disagree")

endmodule
